// ===== design/prefix_varint_encoder_defines.svh =====
// Assertion macros for the prefix varint encoder.
// PVE_ASSERT checks a property on every clock edge outside reset.
// PVE_ASSERT_RST checks a property that also holds during reset.
`ifndef PREFIX_VARINT_ENCODER_DEFINES_SVH
`define PREFIX_VARINT_ENCODER_DEFINES_SVH

`define PVE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define PVE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/pve_pkg.sv =====
// ----------------------------------------------------------------------------
// pve_pkg
// Shared types and constants of the prefix-length varint encoder.
// ----------------------------------------------------------------------------
package pve_pkg;

    localparam int BYTE_W       = 8;
    localparam int MAX_BYTES    = 8;
    localparam int LEN_BITS     = 3;
    localparam int VALUE_W      = BYTE_W * MAX_BYTES;
    localparam int PAYLOAD_BITS = VALUE_W - LEN_BITS;

    typedef struct packed {
        logic [VALUE_W-1:0] value_in;
        logic               final_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_of_value;
        logic              list_end;
        logic              too_large;
    } t_out_item;

endpackage

// ===== design/pve_hold.sv =====
// ----------------------------------------------------------------------------
// pve_hold
// Input register: sizes the value on entry and walks its bytes, most
// significant first, presenting one byte request at a time.
// ----------------------------------------------------------------------------
module pve_hold
    import pve_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    input  logic      i_take,
    output logic      o_byte_valid,
    output t_out_item o_byte
);

    logic [VALUE_W-1:0]  r_val;
    logic                r_fin;
    logic                r_big;
    logic [LEN_BITS-1:0] r_len;
    logic [LEN_BITS-1:0] r_rem;
    logic                r_first;
    logic                r_full;

    logic [LEN_BITS-1:0] n_len;
    logic                n_big;
    logic                last;
    logic                adv;
    logic                done;
    logic                accept;
    logic [BYTE_W-1:0]   sel_byte;

    // smallest L with value below 2^(8L-3); n_len holds L-1
    always_comb begin
        n_len = LEN_BITS'(MAX_BYTES - 1);
        for (int k = MAX_BYTES - 2; k >= 0; k--) begin
            if ((i_in_item.value_in >> (BYTE_W * k + BYTE_W - LEN_BITS)) == '0) begin
                n_len = LEN_BITS'(k);
            end
        end
        n_big = (i_in_item.value_in >> PAYLOAD_BITS) != '0;
    end

    assign last     = r_big || (r_rem == '0);
    assign adv      = r_full && i_take;
    assign done     = adv && last;
    assign accept   = i_in_valid && (!r_full || done);
    assign sel_byte = r_val[{r_rem, 3'b000} +: BYTE_W];

    assign o_in_stall   = r_full && !done;
    assign o_byte_valid = r_full;

    always_comb begin
        o_byte.code_byte     = r_big ? '0 :
                               (sel_byte | (r_first ? {r_len, 5'b00000} : '0));
        o_byte.last_of_value = last;
        o_byte.list_end      = last && r_fin;
        o_byte.too_large     = r_big;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (done) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val   <= i_in_item.value_in;
            r_fin   <= i_in_item.final_value;
            r_big   <= n_big;
            r_len   <= n_len;
            r_rem   <= n_big ? '0 : n_len;
            r_first <= 1'b1;
        end else if (adv) begin
            r_rem   <= r_rem - 1'b1;
            r_first <= 1'b0;
        end
    end

endmodule

// ===== design/pve_outreg.sv =====
// ----------------------------------------------------------------------------
// pve_outreg
// Result register: holds one encoded byte until the consumer takes it.
// ----------------------------------------------------------------------------
module pve_outreg
    import pve_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_byte_valid,
    input  t_out_item i_byte,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_vld;
    t_out_item r_data;

    assign o_take      = !r_vld || !i_out_stall;
    assign o_out_valid = r_vld;
    assign o_out_item  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_byte_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_byte_valid) begin
            r_data <= i_byte;
        end
    end

endmodule

// ===== design/prefix_varint_encoder.sv =====
// Path: an accepted value is held in pve_hold; each byte is registered in pve_outreg.
// Throughput: one byte per cycle while the output is not stalled; a value gives
// L bytes (1 to 8), one if it overflows; the single-byte output lane sets that rate.
// A new value enters as the previous value's last byte moves to the output register.
// Reset: synchronous, active low; clears both valid flags, payload is not reset.
// ----------------------------------------------------------------------------
// prefix_varint_encoder
// Prefix-length varint encoder: 3-bit length field, then value bytes MSB first.
// ----------------------------------------------------------------------------
module prefix_varint_encoder
    import pve_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      take;
    logic      byte_valid;
    t_out_item byte_item;

    pve_hold u_hold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_take       (take),
        .o_byte_valid (byte_valid),
        .o_byte       (byte_item)
    );

    pve_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (byte_item),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== design/pve_checker.sv =====
// ----------------------------------------------------------------------------
// pve_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "prefix_varint_encoder_defines.svh"

module pve_checker
    import pve_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `PVE_ASSERT(a_in_hold,
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item),
        "stalled request changed")
    `PVE_ASSERT(a_out_hold,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item),
        "stalled result changed")
    `PVE_ASSERT(a_big_byte,
        o_out_valid && o_out_item.too_large |->
            o_out_item.last_of_value && (o_out_item.code_byte == '0),
        "overflow byte malformed")
    `PVE_ASSERT(a_end_last,
        o_out_valid && o_out_item.list_end |-> o_out_item.last_of_value,
        "list end off last byte")
    `PVE_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind prefix_varint_encoder pve_checker u_pve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
